[hw/rtl/ufst_pkg.sv]
package ufst_pkg;

   // field widths
   localparam int NODE_W    = 9;
   localparam int WEIGHT_W  = 32;
   localparam int SUM_W     = 41;
   localparam int TALLY_W   = 9;
   localparam int RANK_W    = 4;
   localparam int NCOUNT_W  = 10;
   localparam int CMP_W     = 16;

   // defaults and limits
   localparam int                    MAX_NODES_DEF  = 512;
   localparam logic [NCOUNT_W-1:0]   NODE_COUNT_RST = 10'd512;
   localparam logic [RANK_W-1:0]     RANK_MAX       = 4'd15;
   localparam logic [TALLY_W-1:0]    TALLY_MAX      = 9'd511;
   localparam logic [SUM_W-1:0]      SUM_MAX        = {SUM_W{1'b1}};

   // operation codes
   localparam logic OP_CLEAR = 1'b0;
   localparam logic OP_EDGE  = 1'b1;

   typedef struct packed {
      logic                operation;
      logic [NODE_W-1:0]   node_a;
      logic [NODE_W-1:0]   node_b;
      logic [WEIGHT_W-1:0] weight;
   } req_type;

   typedef struct packed {
      logic               accepted;
      logic               bad_node;
      logic [SUM_W-1:0]   total_weight;
      logic [TALLY_W-1:0] merged_count;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK_A,
      ST_WALK_B,
      ST_UNION,
      ST_RANK_UP
   } state_type;

endpackage

[hw/rtl/union_find_spanning_tree_unit.sv]
// edge item: after accept the block walks endpoint a up to its root, then endpoint b,
//   one parent-table read per step; the union step registers the result strobe; busy
//   through the walks, the union and, when a rank grows, a rank-update step
// clear item: result strobes the next cycle, then busy while a sweep resets the table
// bad endpoint: result strobes the next cycle, busy stays low
// reset: synchronous; a sweep initializes the tables, results never stall
module union_find_spanning_tree_unit #(
   parameter int MAX_NODES = ufst_pkg::MAX_NODES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  ufst_pkg::req_type             req_item,
   output logic                          rsp_valid,
   output ufst_pkg::rsp_type             rsp_item,
   input  logic                          csr_we,
   input  logic [ufst_pkg::NCOUNT_W-1:0] csr_wdata
);

   localparam int AW    = $clog2(MAX_NODES);
   localparam int MEM_W = ufst_pkg::RANK_W + AW;
   localparam logic [AW-1:0] LAST_IDX = AW'(MAX_NODES - 1);

   // control registers
   ufst_pkg::state_type state_ff, state_in;
   logic [AW-1:0]                   cnt_ff, cnt_in;
   logic [ufst_pkg::SUM_W-1:0]      sum_ff, sum_in;
   logic [ufst_pkg::TALLY_W-1:0]    tally_ff, tally_in;
   logic [ufst_pkg::NCOUNT_W-1:0]   nc_ff, nc_in;
   logic                            rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic [AW-1:0]                   cur_ff, cur_in;
   logic [AW-1:0]                   nb_ff, nb_in;
   logic [AW-1:0]                   root_a_ff, root_a_in;
   logic [ufst_pkg::RANK_W-1:0]     rank_a_ff, rank_a_in;
   logic [ufst_pkg::WEIGHT_W-1:0]   w_ff, w_in;
   ufst_pkg::rsp_type               rsp_ff, rsp_in;

   // parent/rank table: {rank, parent}
   logic [MEM_W-1:0]                mem_ff [MAX_NODES];
   logic [MEM_W-1:0]                rd_data_ff;
   logic                            mem_we;
   logic [AW-1:0]                   mem_waddr;
   logic [MEM_W-1:0]                mem_wdata;
   logic [AW-1:0]                   mem_raddr;

   logic [AW-1:0]                   rd_parent;
   logic [ufst_pkg::RANK_W-1:0]     rd_rank;
   logic                            is_root;
   logic                            bad_req;
   logic                            differ;
   logic                            rank_grow;
   logic [ufst_pkg::SUM_W:0]        sum_ext;
   logic [ufst_pkg::SUM_W-1:0]      sum_sat;
   logic [ufst_pkg::TALLY_W-1:0]    tally_inc;

   assign rd_parent = rd_data_ff[AW-1:0];
   assign rd_rank   = rd_data_ff[MEM_W-1:AW];

   // shared compare: current node is its own parent
   assign is_root = (rd_parent == cur_ff);

   // endpoint range check against node_count and table depth
   assign bad_req =
      (ufst_pkg::CMP_W'(req_item.node_a) >= ufst_pkg::CMP_W'(nc_ff)) ||
      (ufst_pkg::CMP_W'(req_item.node_b) >= ufst_pkg::CMP_W'(nc_ff)) ||
      (ufst_pkg::CMP_W'(req_item.node_a) >= ufst_pkg::CMP_W'(MAX_NODES)) ||
      (ufst_pkg::CMP_W'(req_item.node_b) >= ufst_pkg::CMP_W'(MAX_NODES));

   // union decision, root b is the current node at union time
   assign differ    = (root_a_ff != cur_ff);
   assign rank_grow = differ && (rank_a_ff >= rd_rank) && (rank_a_ff == rd_rank) &&
                      (rank_a_ff != ufst_pkg::RANK_MAX);

   // saturating total and tally
   assign sum_ext   = {1'b0, sum_ff} + (ufst_pkg::SUM_W + 1)'(w_ff);
   assign sum_sat   = sum_ext[ufst_pkg::SUM_W] ? ufst_pkg::SUM_MAX
                                               : sum_ext[ufst_pkg::SUM_W-1:0];
   assign tally_inc = (tally_ff == ufst_pkg::TALLY_MAX) ? tally_ff
                                                        : tally_ff + 1'b1;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ufst_pkg::ST_CLEAR: begin
            if (cnt_ff == LAST_IDX) state_in = ufst_pkg::ST_IDLE;
         end
         ufst_pkg::ST_IDLE: begin
            if (start) begin
               if (req_item.operation == ufst_pkg::OP_CLEAR) begin
                  state_in = ufst_pkg::ST_CLEAR;
               end else if (!bad_req) begin
                  state_in = ufst_pkg::ST_WALK_A;
               end
            end
         end
         ufst_pkg::ST_WALK_A: begin
            if (is_root) state_in = ufst_pkg::ST_WALK_B;
         end
         ufst_pkg::ST_WALK_B: begin
            if (is_root) state_in = ufst_pkg::ST_UNION;
         end
         ufst_pkg::ST_UNION: begin
            state_in = rank_grow ? ufst_pkg::ST_RANK_UP : ufst_pkg::ST_IDLE;
         end
         ufst_pkg::ST_RANK_UP: begin
            state_in = ufst_pkg::ST_IDLE;
         end
         default: begin
            state_in = ufst_pkg::ST_CLEAR;
         end
      endcase
   end

   // datapath and table control
   always_comb begin
      cnt_in       = cnt_ff;
      sum_in       = sum_ff;
      tally_in     = tally_ff;
      nc_in        = csr_we ? csr_wdata : nc_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      cur_in       = cur_ff;
      nb_in        = nb_ff;
      root_a_in    = root_a_ff;
      rank_a_in    = rank_a_ff;
      w_in         = w_ff;
      mem_we       = 1'b0;
      mem_waddr    = cnt_ff;
      mem_wdata    = {{ufst_pkg::RANK_W{1'b0}}, cnt_ff};
      mem_raddr    = cur_ff;
      case (state_ff)
         ufst_pkg::ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = cnt_ff;
            mem_wdata = {{ufst_pkg::RANK_W{1'b0}}, cnt_ff};
            cnt_in    = (cnt_ff == LAST_IDX) ? '0 : cnt_ff + 1'b1;
         end
         ufst_pkg::ST_IDLE: begin
            mem_raddr = AW'(req_item.node_a);
            cur_in    = AW'(req_item.node_a);
            nb_in     = AW'(req_item.node_b);
            w_in      = req_item.weight;
            cnt_in    = '0;
            if (start) begin
               if (req_item.operation == ufst_pkg::OP_CLEAR) begin
                  sum_in       = '0;
                  tally_in     = '0;
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{accepted: 1'b0, bad_node: 1'b0,
                                   total_weight: '0, merged_count: '0};
               end else if (bad_req) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{accepted: 1'b0, bad_node: 1'b1,
                                   total_weight: sum_ff, merged_count: tally_ff};
               end
            end
         end
         ufst_pkg::ST_WALK_A: begin
            if (is_root) begin
               root_a_in = cur_ff;
               rank_a_in = rd_rank;
               mem_raddr = nb_ff;
               cur_in    = nb_ff;
            end else begin
               mem_raddr = rd_parent;
               cur_in    = rd_parent;
            end
         end
         ufst_pkg::ST_WALK_B: begin
            if (!is_root) begin
               mem_raddr = rd_parent;
               cur_in    = rd_parent;
            end
         end
         ufst_pkg::ST_UNION: begin
            rsp_valid_in = 1'b1;
            if (differ) begin
               mem_we = 1'b1;
               if (rank_a_ff < rd_rank) begin
                  mem_waddr = root_a_ff;
                  mem_wdata = {rank_a_ff, cur_ff};
               end else begin
                  mem_waddr = cur_ff;
                  mem_wdata = {rd_rank, root_a_ff};
               end
               sum_in   = sum_sat;
               tally_in = tally_inc;
               rsp_in   = '{accepted: 1'b1, bad_node: 1'b0,
                            total_weight: sum_sat, merged_count: tally_inc};
            end else begin
               rsp_in   = '{accepted: 1'b0, bad_node: 1'b0,
                            total_weight: sum_ff, merged_count: tally_ff};
            end
         end
         ufst_pkg::ST_RANK_UP: begin
            mem_we    = 1'b1;
            mem_waddr = root_a_ff;
            mem_wdata = {ufst_pkg::RANK_W'(rank_a_ff + 1'b1), root_a_ff};
         end
         default: begin
            cnt_in = '0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ufst_pkg::ST_CLEAR;
         cnt_ff       <= '0;
         sum_ff       <= '0;
         tally_ff     <= '0;
         nc_ff        <= ufst_pkg::NODE_COUNT_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         sum_ff       <= sum_in;
         tally_ff     <= tally_in;
         nc_ff        <= nc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      nb_ff     <= nb_in;
      root_a_ff <= root_a_in;
      rank_a_ff <= rank_a_in;
      w_ff      <= w_in;
      rsp_ff    <= rsp_in;
   end

   // table memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) mem_ff[mem_waddr] <= mem_wdata;
      rd_data_ff <= mem_ff[mem_raddr];
   end

   assign busy      = (state_ff != ufst_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // a clear beat answers next cycle with zeroed totals
   a_clear_rsp: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_item.operation == ufst_pkg::OP_CLEAR)
      |=> rsp_valid && (rsp_item.total_weight == '0) && (rsp_item.merged_count == '0))
      else $error("clear beat did not produce a zeroed result");

   // an accepted edge never carries the bad-node flag
   a_acc_not_bad: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_item.accepted && rsp_item.bad_node))
      else $error("result both accepted and bad");

   // an accepted edge bumps the tally by one unless saturated
   a_tally_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.accepted && ($past(tally_ff) != ufst_pkg::TALLY_MAX)
      |-> (rsp_item.merged_count == $past(tally_ff) + 1'b1))
      else $error("merged count did not advance by one");

   // root walks only read the table
   a_walk_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ufst_pkg::ST_WALK_A) || (state_ff == ufst_pkg::ST_WALK_B)
      |-> !mem_we)
      else $error("table written during root walk");

   // the table is never read-walked while the sweep is unfinished
   a_sweep_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ufst_pkg::ST_CLEAR) |=> busy || $past(cnt_ff == LAST_IDX))
      else $error("sweep left early");

endmodule

[tb/union_find_spanning_tree_unit_tb.sv]
`timescale 1ns / 1ps

module union_find_spanning_tree_unit_tb;

   localparam int CYCLE_LIMIT  = 600000;
   localparam int REPORT_CAP   = 10;
   localparam int RANDOM_BEATS = 1250;
   localparam int DRAIN_CYCLES = 64;
   localparam int PEND_DEPTH   = 64;
   localparam int DIR_DEPTH    = 32;

   typedef enum logic {ROW_BEAT, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type                  kind;
      logic                          typed;
      ufst_pkg::req_type             beat;
      ufst_pkg::rsp_type             want;
      logic [ufst_pkg::NCOUNT_W-1:0] csr_value;
   } stim_row_type;

   logic                          clock;
   logic                          reset;
   logic                          start;
   logic                          busy;
   ufst_pkg::req_type             req_item;
   logic                          rsp_valid;
   ufst_pkg::rsp_type             rsp_item;
   logic                          csr_we;
   logic [ufst_pkg::NCOUNT_W-1:0] csr_wdata;

   // forest predictor state
   logic [ufst_pkg::NODE_W-1:0]   tree_parent [ufst_pkg::MAX_NODES_DEF];
   logic [ufst_pkg::RANK_W-1:0]   tree_rank [ufst_pkg::MAX_NODES_DEF];
   logic [ufst_pkg::SUM_W-1:0]    span_sum;
   logic [ufst_pkg::TALLY_W-1:0]  span_edges;
   logic [ufst_pkg::NCOUNT_W-1:0] node_limit;

   // expected results in arrival order, ring of predictions
   ufst_pkg::rsp_type pending_rsp [PEND_DEPTH];
   int unsigned       pend_wr = 0;
   int unsigned       pend_rd = 0;

   // directed stimulus table
   stim_row_type dir_rows [DIR_DEPTH];
   int unsigned  dir_count = 0;

   int unsigned cycle_count = 0;
   int unsigned beats_sent  = 0;
   int unsigned rsp_checked = 0;
   int unsigned error_count = 0;
   int unsigned clears_seen = 0;
   int unsigned bad_seen    = 0;
   int unsigned joins_seen  = 0;
   logic [ufst_pkg::TALLY_W-1:0] peak_edges = '0;
   bit burst_mode = 1'b0;

   union_find_spanning_tree_unit #(
      .MAX_NODES(ufst_pkg::MAX_NODES_DEF)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_item (req_item),
      .rsp_valid(rsp_valid),
      .rsp_item (rsp_item),
      .csr_we   (csr_we),
      .csr_wdata(csr_wdata)
   );

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // every node back to its own root, totals to zero
   function automatic void forest_clear();
      for (int i = 0; i < ufst_pkg::MAX_NODES_DEF; i++) begin
         tree_parent[i] = ufst_pkg::NODE_W'(i);
         tree_rank[i]   = '0;
      end
      span_sum   = '0;
      span_edges = '0;
   endfunction

   // follow parent links up to the root, bounded walk
   function automatic logic [ufst_pkg::NODE_W-1:0] find_root(
      input logic [ufst_pkg::NODE_W-1:0] node);
      logic [ufst_pkg::NODE_W-1:0] cur;
      cur = node;
      for (int s = 0; s < ufst_pkg::MAX_NODES_DEF; s++) begin
         if (tree_parent[cur] == cur) begin
            break;
         end
         cur = tree_parent[cur];
      end
      return cur;
   endfunction

   // union by rank and running total for one request beat
   function automatic ufst_pkg::rsp_type forest_step(input ufst_pkg::req_type beat);
      ufst_pkg::rsp_type           res;
      int unsigned                 lim;
      logic [ufst_pkg::NODE_W-1:0] root_a;
      logic [ufst_pkg::NODE_W-1:0] root_b;
      logic [ufst_pkg::SUM_W:0]    grown;
      res = '0;
      lim = (node_limit > 10'd512) ? ufst_pkg::MAX_NODES_DEF : node_limit;
      if (beat.operation == ufst_pkg::OP_CLEAR) begin
         forest_clear();
      end else if (beat.node_a >= lim || beat.node_b >= lim) begin
         res.bad_node = 1'b1;
      end else begin
         root_a = find_root(beat.node_a);
         root_b = find_root(beat.node_b);
         if (root_a != root_b) begin
            if (tree_rank[root_a] < tree_rank[root_b]) begin
               tree_parent[root_a] = root_b;
            end else begin
               tree_parent[root_b] = root_a;
               if (tree_rank[root_a] == tree_rank[root_b] &&
                   tree_rank[root_a] != ufst_pkg::RANK_MAX) begin
                  tree_rank[root_a]++;
               end
            end
            grown    = {1'b0, span_sum} + beat.weight;
            span_sum = (grown > ufst_pkg::SUM_MAX) ? ufst_pkg::SUM_MAX
                                                   : grown[ufst_pkg::SUM_W-1:0];
            if (span_edges != ufst_pkg::TALLY_MAX) begin
               span_edges++;
            end
            res.accepted = 1'b1;
         end
      end
      res.total_weight = span_sum;
      res.merged_count = span_edges;
      return res;
   endfunction

   function automatic ufst_pkg::req_type link_beat(input logic [ufst_pkg::NODE_W-1:0] a, b,
                                                   input logic [ufst_pkg::WEIGHT_W-1:0] w);
      ufst_pkg::req_type beat;
      beat.operation = ufst_pkg::OP_EDGE;
      beat.node_a    = a;
      beat.node_b    = b;
      beat.weight    = w;
      return beat;
   endfunction

   // clear with random payload in the fields it ignores
   function automatic ufst_pkg::req_type clear_beat();
      ufst_pkg::req_type beat;
      beat.operation = ufst_pkg::OP_CLEAR;
      beat.node_a    = ufst_pkg::NODE_W'($urandom());
      beat.node_b    = ufst_pkg::NODE_W'($urandom());
      beat.weight    = $urandom();
      return beat;
   endfunction

   function automatic stim_row_type beat_row(input logic op,
                                             input logic [ufst_pkg::NODE_W-1:0] a, b,
                                             input logic [ufst_pkg::WEIGHT_W-1:0] w,
                                             input logic typed,
                                             input ufst_pkg::rsp_type want);
      stim_row_type row;
      row                = '0;
      row.kind           = ROW_BEAT;
      row.typed          = typed;
      row.beat           = link_beat(a, b, w);
      row.beat.operation = op;
      row.want           = want;
      return row;
   endfunction

   function automatic stim_row_type csr_row(input logic [ufst_pkg::NCOUNT_W-1:0] value);
      stim_row_type row;
      row           = '0;
      row.kind      = ROW_CSR;
      row.csr_value = value;
      return row;
   endfunction

   // append one row to the directed table
   function automatic void add_row(input stim_row_type row);
      dir_rows[dir_count] = row;
      dir_count++;
   endfunction

   // one request beat: optional idle gap, then hold start until the block takes it
   task automatic send_beat(input ufst_pkg::req_type beat, input logic typed,
                            input ufst_pkg::rsp_type want);
      ufst_pkg::rsp_type predicted;
      int unsigned       gap;
      gap = burst_mode ? 0 : $urandom_range(0, 19);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= beat;
      do begin
         @(posedge clock);
      end while (busy);
      predicted = forest_step(beat);
      pending_rsp[pend_wr % PEND_DEPTH] = typed ? want : predicted;
      pend_wr++;
      beats_sent++;
      if (beat.operation == ufst_pkg::OP_CLEAR) begin
         clears_seen++;
      end
   endtask

   // drop start, drain all results and wait for the block to go idle
   task automatic settle_idle();
      start <= 1'b0;
      while (pend_wr != pend_rd) @(posedge clock);
      do begin
         @(posedge clock);
      end while (busy);
   endtask

   task automatic write_node_count(input logic [ufst_pkg::NCOUNT_W-1:0] value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we     <= 1'b0;
      node_limit = value;
   endtask

   // spanning tree over all nodes, weights climbing to the top of the range
   task automatic grow_full_tree();
      logic [ufst_pkg::NODE_W-1:0]   order [ufst_pkg::MAX_NODES_DEF];
      logic [ufst_pkg::NODE_W-1:0]   swap;
      logic [ufst_pkg::WEIGHT_W-1:0] w;
      int unsigned                   step;
      int unsigned                   pick;
      int unsigned                   k;
      settle_idle();
      write_node_count(10'd512);
      for (int i = 0; i < ufst_pkg::MAX_NODES_DEF; i++) begin
         order[i] = ufst_pkg::NODE_W'(i);
      end
      for (int i = ufst_pkg::MAX_NODES_DEF - 1; i > 0; i--) begin
         pick        = $urandom_range(0, i);
         swap        = order[i];
         order[i]    = order[pick];
         order[pick] = swap;
      end
      send_beat(clear_beat(), 1'b0, '0);
      w = 32'hF800_0000 | $urandom_range(0, 255);
      k = 1;
      while (k < ufst_pkg::MAX_NODES_DEF) begin
         if (beats_sent % 64 == 0) begin
            burst_mode = ($urandom_range(0, 2) == 0);
         end
         step = $urandom_range(0, 32'h0008_0000);
         w    = (w > 32'hFFFF_FFFF - step) ? 32'hFFFF_FFFF : w + step;
         if ($urandom_range(0, 9) == 0) begin
            // both ends already joined, must be turned away
            send_beat(link_beat(order[$urandom_range(0, k - 1)],
                                order[$urandom_range(0, k - 1)], w), 1'b0, '0);
         end else begin
            pick = $urandom_range(0, k - 1);
            if ($urandom_range(0, 1) == 0) begin
               send_beat(link_beat(order[k], order[pick], w), 1'b0, '0);
            end else begin
               send_beat(link_beat(order[pick], order[k], w), 1'b0, '0);
            end
            k++;
         end
      end
   endtask

   // small graph: clear, then mostly sorted edges with some noise mixed in
   task automatic run_small_graph();
      logic [ufst_pkg::NCOUNT_W-1:0] n_cfg;
      logic [ufst_pkg::WEIGHT_W-1:0] w;
      logic [ufst_pkg::NODE_W-1:0]   a;
      logic [ufst_pkg::NODE_W-1:0]   b;
      int unsigned                   span;
      int unsigned                   n_links;
      int unsigned                   r;
      case ($urandom_range(0, 11))
         0: n_cfg = 10'd1;
         1: n_cfg = 10'd2;
         2: n_cfg = 10'd0;
         3: n_cfg = ufst_pkg::NCOUNT_W'($urandom_range(513, 1023));
         4: n_cfg = 10'd512;
         5: n_cfg = ufst_pkg::NCOUNT_W'($urandom_range(49, 511));
         default: n_cfg = ufst_pkg::NCOUNT_W'($urandom_range(3, 48));
      endcase
      span = (n_cfg > 10'd512) ? ufst_pkg::MAX_NODES_DEF : n_cfg;
      settle_idle();
      write_node_count(n_cfg);
      burst_mode = ($urandom_range(0, 3) == 0);
      send_beat(clear_beat(), 1'b0, '0);
      n_links = $urandom_range(8, 40);
      w = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 32'h0000_FFFF);
      for (int k = 0; k < n_links; k++) begin
         w = (w > 32'hFFFF_FFFF - 32'd600) ? w : w + $urandom_range(0, 600);
         r = $urandom_range(0, 19);
         if (span == 0) begin
            a = ufst_pkg::NODE_W'($urandom());
            b = ufst_pkg::NODE_W'($urandom());
         end else begin
            a = ufst_pkg::NODE_W'($urandom_range(0, span - 1));
            b = ufst_pkg::NODE_W'($urandom_range(0, span - 1));
         end
         if (r == 2) begin
            send_beat(clear_beat(), 1'b0, '0);
         end else begin
            if (r == 0 && span < ufst_pkg::MAX_NODES_DEF) begin
               // endpoint past the node count
               if ($urandom_range(0, 1) == 0) begin
                  a = ufst_pkg::NODE_W'($urandom_range(span, ufst_pkg::MAX_NODES_DEF - 1));
               end else begin
                  b = ufst_pkg::NODE_W'($urandom_range(span, ufst_pkg::MAX_NODES_DEF - 1));
               end
            end else if (r == 1) begin
               b = a;
            end
            // r == 3 breaks the ascending order
            send_beat(link_beat(a, b, (r == 3) ? $urandom() : w), 1'b0, '0);
         end
      end
   endtask

   // result beat checker
   always @(posedge clock) begin
      ufst_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         if (pend_wr == pend_rd) begin
            error_count++;
            if (error_count <= REPORT_CAP) begin
               $display("unexpected result at cycle %0d: acc=%0b bad=%0b total=%h count=%0d",
                        cycle_count, rsp_item.accepted, rsp_item.bad_node,
                        rsp_item.total_weight, rsp_item.merged_count);
            end
         end else begin
            want = pending_rsp[pend_rd % PEND_DEPTH];
            pend_rd++;
            rsp_checked++;
            if (rsp_item.accepted !== want.accepted || rsp_item.bad_node !== want.bad_node ||
                rsp_item.total_weight !== want.total_weight ||
                rsp_item.merged_count !== want.merged_count) begin
               error_count++;
               if (error_count <= REPORT_CAP) begin
                  $display("mismatch at cycle %0d: want acc=%0b bad=%0b total=%h count=%0d",
                           cycle_count, want.accepted, want.bad_node,
                           want.total_weight, want.merged_count);
                  $display("                       got acc=%0b bad=%0b total=%h count=%0d",
                           rsp_item.accepted, rsp_item.bad_node,
                           rsp_item.total_weight, rsp_item.merged_count);
               end
            end
            if (want.accepted) begin
               joins_seen++;
            end
            if (want.bad_node) begin
               bad_seen++;
            end
            if (want.merged_count > peak_edges) begin
               peak_edges = want.merged_count;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pend_wr - pend_rd);
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      stim_row_type row;
      reset     <= 1'b1;
      start     <= 1'b0;
      req_item  <= '0;
      csr_we    <= 1'b0;
      csr_wdata <= '0;
      node_limit = ufst_pkg::NODE_COUNT_RST;
      forest_clear();

      // directed rows: extremes, bad endpoints, self loop, node count corners
      add_row(csr_row(10'd512));
      add_row(beat_row(ufst_pkg::OP_EDGE, 9'd0, 9'd1, 32'h0000_0100, 1'b1,
                       ufst_pkg::rsp_type'{1'b1, 1'b0, 41'h100, 9'd1}));
      add_row(beat_row(ufst_pkg::OP_EDGE, 9'd1, 9'd0, 32'h0000_0200, 1'b1,
                       ufst_pkg::rsp_type'{1'b0, 1'b0, 41'h100, 9'd1}));
      add_row(beat_row(ufst_pkg::OP_EDGE, 9'd5, 9'd5, 32'h0000_0300, 1'b1,
                       ufst_pkg::rsp_type'{1'b0, 1'b0, 41'h100, 9'd1}));
      add_row(beat_row(ufst_pkg::OP_EDGE, 9'd511, 9'd0, 32'hFFFF_FFFF, 1'b1,
                       ufst_pkg::rsp_type'{1'b1, 1'b0, 41'h1_0000_00FF, 9'd2}));
      add_row(beat_row(ufst_pkg::OP_EDGE, 9'd510, 9'd511, 32'hFFFF_FFFF, 1'b0, '0));
      add_row(beat_row(ufst_pkg::OP_EDGE, 9'd2, 9'd510, 32'hFFFF_FFFF, 1'b0, '0));
      add_row(beat_row(ufst_pkg::OP_CLEAR, 9'd511, 9'd511, 32'hFFFF_FFFF, 1'b1,
                       ufst_pkg::rsp_type'{1'b0, 1'b0, 41'h0, 9'd0}));
      add_row(csr_row(10'd10));
      add_row(beat_row(ufst_pkg::OP_EDGE, 9'd9, 9'd10, 32'h0000_0001, 1'b1,
                       ufst_pkg::rsp_type'{1'b0, 1'b1, 41'h0, 9'd0}));
      add_row(beat_row(ufst_pkg::OP_EDGE, 9'd10, 9'd0, 32'h0000_0001, 1'b1,
                       ufst_pkg::rsp_type'{1'b0, 1'b1, 41'h0, 9'd0}));
      add_row(beat_row(ufst_pkg::OP_EDGE, 9'd0, 9'd9, 32'h0000_0005, 1'b1,
                       ufst_pkg::rsp_type'{1'b1, 1'b0, 41'h5, 9'd1}));
      add_row(beat_row(ufst_pkg::OP_EDGE, 9'd3, 9'd9, 32'h0000_0006, 1'b0, '0));
      add_row(beat_row(ufst_pkg::OP_EDGE, 9'd3, 9'd0, 32'h0000_0007, 1'b0, '0));
      add_row(csr_row(10'd0));
      add_row(beat_row(ufst_pkg::OP_EDGE, 9'd0, 9'd0, 32'h0000_0008, 1'b0, '0));
      add_row(csr_row(10'd1023));
      add_row(beat_row(ufst_pkg::OP_EDGE, 9'd511, 9'd100, 32'h0000_0009, 1'b0, '0));
      add_row(csr_row(10'd1));
      add_row(beat_row(ufst_pkg::OP_EDGE, 9'd0, 9'd0, 32'h0000_000A, 1'b0, '0));
      add_row(beat_row(ufst_pkg::OP_EDGE, 9'd0, 9'd1, 32'h0000_000B, 1'b0, '0));
      add_row(csr_row(10'd2));
      add_row(beat_row(ufst_pkg::OP_EDGE, 9'd1, 9'd0, 32'h0000_0000, 1'b0, '0));
      add_row(beat_row(ufst_pkg::OP_CLEAR, 9'd0, 9'd0, 32'h0000_0000, 1'b1,
                       ufst_pkg::rsp_type'{1'b0, 1'b0, 41'h0, 9'd0}));
      add_row(csr_row(10'd512));

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < dir_count; i++) begin
         row = dir_rows[i];
         if (row.kind == ROW_CSR) begin
            settle_idle();
            write_node_count(row.csr_value);
         end else begin
            send_beat(row.beat, row.typed, row.want);
         end
      end

      // random part: one full tree, then many small graphs
      grow_full_tree();
      while (beats_sent < RANDOM_BEATS + dir_count) begin
         run_small_graph();
      end

      settle_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d request beats including %0d clears, %0d results checked",
               beats_sent, clears_seen, rsp_checked);
      $display("%0d edges joined sets, %0d bad endpoints, largest merged count %0d",
               joins_seen, bad_seen, peak_edges);
      if (error_count == 0 && pend_wr == pend_rd) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d errors, %0d results never arrived", error_count, pend_wr - pend_rd);
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

[union_find_spanning_tree_unit.f]
hw/rtl/ufst_pkg.sv
hw/rtl/union_find_spanning_tree_unit.sv
tb/union_find_spanning_tree_unit_tb.sv
